### rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/ers_pkg.sv
package ers_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int ERR_BITS     = SAMPLE_BITS + 1;
   localparam int COUNT_BITS   = 17;
   localparam int MAX_SAMPLES  = 65536;
   localparam int SUM_BITS     = 64;
   localparam int SQ_BITS      = 2 * SAMPLE_BITS + 1;
   localparam int DIV_BITS     = SUM_BITS + 16;
   localparam int SQRT_STEPS   = 32;
   localparam int LOG_FRAC     = 24;
   localparam int LOG_BITS     = 30;
   localparam int ACC_BITS     = 33;
   localparam int STEP_BITS    = 7;
   localparam int QUEUE_DEPTH  = 2;
   localparam logic [31:0] TEN_LOG10_2_Q30 = 32'd3232284966;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_ERROR = 2'd1;
   localparam logic [1:0] STATUS_ZERO_RANGE = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] original_sample;
      logic signed [SAMPLE_BITS-1:0] reconstructed_sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic [31:0]                   rmse;
      logic [SAMPLE_BITS-1:0]        max_abs_error;
      logic signed [15:0]            psnr_db;
      logic signed [SAMPLE_BITS-1:0] original_min;
      logic signed [SAMPLE_BITS-1:0] original_max;
      logic [COUNT_BITS-1:0]         sample_total;
      logic [1:0]                    status;
   } rsp_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]           sum_squares;
      logic [ERR_BITS-1:0]           max_error;
      logic signed [SAMPLE_BITS-1:0] min_val;
      logic signed [SAMPLE_BITS-1:0] max_val;
      logic [COUNT_BITS-1:0]         count;
   } snap_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef enum logic [3:0] {
      B_IDLE, B_DIV, B_SQRT, B_CHECK, B_LOGNORM, B_LOGSQ, B_SCALE, B_ROUND, B_OUT
   } back_state_type;

endpackage

### rtl/core/ers_front.sv
module ers_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ers_pkg::req_type  req_data,
   output logic              snap_push,
   output ers_pkg::snap_type snap_data,
   input  logic              snap_full
);
   import ers_pkg::*;

   logic                          s1_valid_ff;
   logic                          s1_last_ff;
   logic signed [SAMPLE_BITS-1:0] s1_a_ff;
   logic [ERR_BITS-1:0]           s1_ad_ff;
   logic [SQ_BITS-1:0]            s1_sq_ff;

   logic [SUM_BITS-1:0]           sum_ff, sum_in;
   logic [ERR_BITS-1:0]           err_ff, err_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic [COUNT_BITS-1:0]         cnt_ff, cnt_in;

   logic                          advance, accept, consume, first;
   logic signed [ERR_BITS-1:0]    diff;
   logic [ERR_BITS-1:0]           abs_diff;
   logic [2*ERR_BITS-1:0]         square;
   logic [SUM_BITS:0]             sum_wide;

   assign advance = !(s1_valid_ff && s1_last_ff && snap_full);
   assign full    = !advance;
   assign accept  = push && advance;
   assign consume = s1_valid_ff && advance;

   assign diff = {req_data.original_sample[SAMPLE_BITS-1], req_data.original_sample}
               - {req_data.reconstructed_sample[SAMPLE_BITS-1],
                  req_data.reconstructed_sample};
   assign abs_diff = diff[ERR_BITS-1] ? ERR_BITS'(-diff) : ERR_BITS'(diff);
   assign square   = abs_diff * abs_diff;

   // pipeline stage: difference and square
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= push;
      end
      if (accept) begin
         s1_last_ff <= req_data.last_sample;
         s1_a_ff    <= req_data.original_sample;
         s1_ad_ff   <= abs_diff;
         s1_sq_ff   <= square[SQ_BITS-1:0];
      end
   end

   assign first    = (cnt_ff == '0);
   assign sum_wide = {1'b0, sum_ff} + (SUM_BITS+1)'(s1_sq_ff);

   always_comb begin
      sum_in = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
      err_in = (s1_ad_ff > err_ff) ? s1_ad_ff : err_ff;
      min_in = (first || s1_a_ff < min_ff) ? s1_a_ff : min_ff;
      max_in = (first || s1_a_ff > max_ff) ? s1_a_ff : max_ff;
      cnt_in = (cnt_ff < COUNT_BITS'(MAX_SAMPLES)) ? cnt_ff + 1'b1 : cnt_ff;
   end

   assign snap_push             = consume && s1_last_ff;
   assign snap_data.sum_squares = sum_in;
   assign snap_data.max_error   = err_in;
   assign snap_data.min_val     = min_in;
   assign snap_data.max_val     = max_in;
   assign snap_data.count       = cnt_in;

   always_ff @(posedge clock) begin
      if (reset || snap_push) begin
         sum_ff <= '0;
         err_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
         cnt_ff <= '0;
      end else if (consume) begin
         sum_ff <= sum_in;
         err_ff <= err_in;
         min_ff <= min_in;
         max_ff <= max_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/core/ers_queue.sv
module ers_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ers_pkg::queue_ctl_type ctl,
   input  ers_pkg::snap_type      wr_data,
   output ers_pkg::snap_type      rd_data,
   output logic                   q_full,
   output logic                   q_empty
);
   import ers_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   snap_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]     used_ff;
   logic                  do_push, do_pop;

   assign q_full  = (used_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign q_empty = (used_ff == '0);
   assign do_push = ctl.push && !q_full;
   assign do_pop  = ctl.pop && !q_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         used_ff <= used_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/ers_back.sv
module ers_back (
   input  logic              clock,
   input  logic              reset,
   input  ers_pkg::snap_type snap_data,
   input  logic              snap_empty,
   output logic              snap_pop,
   output logic              empty,
   input  logic              pop,
   output ers_pkg::rsp_type  rsp_data
);
   import ers_pkg::*;

   back_state_type state_ff, state_in;

   snap_type              snap_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [DIV_BITS-1:0]   dvd_ff;
   logic [SUM_BITS-1:0]   sv_ff, sr_ff, sb_ff;
   logic [SUM_BITS-1:0]   lv_ff;
   logic [5:0]            le_ff;
   logic [31:0]           lm_ff;
   logic [LOG_FRAC-1:0]   lf_ff;
   logic [1:0]            lsel_ff;
   logic signed [ACC_BITS-1:0] dacc_ff;
   logic [63:0]           prod_ff;
   logic [31:0]           rmse_ff;
   logic signed [15:0]    psnr_ff;
   logic [1:0]            status_ff;
   logic                  out_valid_ff;
   rsp_type               rsp_ff;

   logic                  out_load, div_last, sqrt_last, log_last, sat;
   logic [COUNT_BITS:0]   rem_sh;
   logic                  div_ge;
   logic [COUNT_BITS-1:0] rem_next;
   logic [DIV_BITS-1:0]   dvd_next;
   logic [SUM_BITS-1:0]   trial, sv_next, sr_next;
   logic                  sqrt_ok;
   logic [63:0]           sq_prod;
   logic [ERR_BITS-1:0]   range;
   logic [ACC_BITS-1:0]   log_val;
   logic signed [ACC_BITS-1:0] dacc_next;
   logic [31:0]           mag;
   logic [63:0]           rounded;

   assign div_last  = (step_ff == STEP_BITS'(DIV_BITS-1));
   assign sqrt_last = (step_ff == STEP_BITS'(SQRT_STEPS-1));
   assign log_last  = (step_ff == STEP_BITS'(LOG_FRAC-1));

   // restoring divide, one quotient bit per cycle
   assign rem_sh   = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign div_ge   = (rem_sh >= {1'b0, snap_ff.count});
   assign rem_next = div_ge ? COUNT_BITS'(rem_sh - {1'b0, snap_ff.count})
                            : rem_sh[COUNT_BITS-1:0];
   assign dvd_next = {dvd_ff[DIV_BITS-2:0], div_ge};
   assign sat      = (dvd_next[DIV_BITS-1:SUM_BITS] != '0);

   // integer square root, one result bit per cycle
   assign trial   = sr_ff + sb_ff;
   assign sqrt_ok = (sv_ff >= trial);
   assign sv_next = sqrt_ok ? sv_ff - trial : sv_ff;
   assign sr_next = sqrt_ok ? (sr_ff >> 1) + sb_ff : (sr_ff >> 1);

   assign range = {snap_ff.max_val[SAMPLE_BITS-1], snap_ff.max_val}
                - {snap_ff.min_val[SAMPLE_BITS-1], snap_ff.min_val};

   assign sq_prod = lm_ff * lm_ff;
   assign log_val = ACC_BITS'({le_ff, lf_ff[LOG_FRAC-2:0], sq_prod[63]});

   always_comb begin
      case (lsel_ff)
         2'd0:    dacc_next = dacc_ff + $signed(log_val << 1);
         2'd1:    dacc_next = dacc_ff + $signed(log_val);
         default: dacc_next = dacc_ff - $signed(log_val);
      endcase
   end

   assign mag     = dacc_ff[ACC_BITS-1] ? 32'(-dacc_ff) : 32'(dacc_ff);
   assign rounded = (prod_ff + 64'(1) * (64'd1 << 45)) >> 46;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:    if (!snap_empty) state_in = B_DIV;
         B_DIV:     if (div_last) state_in = sat ? B_CHECK : B_SQRT;
         B_SQRT:    if (sqrt_last) state_in = B_CHECK;
         B_CHECK: begin
            if (range == '0 || snap_ff.sum_squares == '0) begin
               state_in = B_OUT;
            end else begin
               state_in = B_LOGNORM;
            end
         end
         B_LOGNORM: if (lv_ff[SUM_BITS-1]) state_in = B_LOGSQ;
         B_LOGSQ: begin
            if (log_last) state_in = (lsel_ff == 2'd2) ? B_SCALE : B_LOGNORM;
         end
         B_SCALE:   state_in = B_ROUND;
         B_ROUND:   state_in = B_OUT;
         B_OUT:     if (!out_valid_ff || pop) state_in = B_IDLE;
         default:   state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      snap_pop = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         B_IDLE:  snap_pop = !snap_empty;
         B_OUT:   out_load = !out_valid_ff || pop;
         default: begin
            snap_pop = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            snap_ff <= snap_data;
            rem_ff  <= '0;
            dvd_ff  <= {snap_data.sum_squares, 16'd0};
            step_ff <= '0;
         end
         B_DIV: begin
            rem_ff  <= rem_next;
            dvd_ff  <= dvd_next;
            step_ff <= step_ff + 1'b1;
            if (div_last) begin
               step_ff <= '0;
               rmse_ff <= '1;
               sv_ff   <= dvd_next[SUM_BITS-1:0];
               sr_ff   <= '0;
               sb_ff   <= SUM_BITS'(1) << (SUM_BITS - 2);
            end
         end
         B_SQRT: begin
            sv_ff   <= sv_next;
            sr_ff   <= sr_next;
            sb_ff   <= sb_ff >> 2;
            step_ff <= step_ff + 1'b1;
            if (sqrt_last) begin
               rmse_ff <= sr_next[31:0];
            end
         end
         B_CHECK: begin
            lsel_ff <= 2'd0;
            dacc_ff <= '0;
            lv_ff   <= SUM_BITS'(range);
            le_ff   <= 6'd63;
            step_ff <= '0;
            if (range == '0) begin
               status_ff <= STATUS_ZERO_RANGE;
               psnr_ff   <= '0;
            end else if (snap_ff.sum_squares == '0) begin
               status_ff <= STATUS_ZERO_ERROR;
               psnr_ff   <= 16'sd32767;
            end else begin
               status_ff <= STATUS_OK;
            end
         end
         B_LOGNORM: begin
            if (lv_ff[SUM_BITS-1]) begin
               lm_ff   <= lv_ff[SUM_BITS-1:32];
               lf_ff   <= '0;
               step_ff <= '0;
            end else begin
               lv_ff <= lv_ff << 1;
               le_ff <= le_ff - 1'b1;
            end
         end
         B_LOGSQ: begin
            lm_ff   <= sq_prod[63] ? sq_prod[63:32] : sq_prod[62:31];
            lf_ff   <= {lf_ff[LOG_FRAC-2:0], sq_prod[63]};
            step_ff <= step_ff + 1'b1;
            if (log_last) begin
               dacc_ff <= dacc_next;
               lsel_ff <= lsel_ff + 1'b1;
               le_ff   <= 6'd63;
               case (lsel_ff)
                  2'd0:    lv_ff <= SUM_BITS'(snap_ff.count);
                  default: lv_ff <= snap_ff.sum_squares;
               endcase
            end
         end
         B_SCALE: begin
            prod_ff <= 64'(mag) * 64'(TEN_LOG10_2_Q30);
         end
         B_ROUND: begin
            if (dacc_ff[ACC_BITS-1]) begin
               psnr_ff <= (rounded > 64'd32768) ? -16'sd32768 : 16'(-rounded);
            end else begin
               psnr_ff <= (rounded > 64'd32767) ? 16'sd32767 : 16'(rounded);
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
      if (out_load) begin
         rsp_ff.rmse          <= rmse_ff;
         rsp_ff.max_abs_error <= snap_ff.max_error[ERR_BITS-1]
                                 ? '1 : snap_ff.max_error[SAMPLE_BITS-1:0];
         rsp_ff.psnr_db       <= psnr_ff;
         rsp_ff.original_min  <= snap_ff.min_val;
         rsp_ff.original_max  <= snap_ff.max_val;
         rsp_ff.sample_total  <= snap_ff.count;
         rsp_ff.status        <= status_ff;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

### rtl/core/error_stats_rmse_psnr.sv
// Error statistics over sets of (original, reconstructed) sample pairs.
// Pairs go in through a queue-style port, one pair per cycle sustained; the
// front accumulates the saturating sum of squared differences, max error,
// original min/max and the pair count, and on the pair marked last hands a
// snapshot to a two-entry queue and clears. The back turns each snapshot
// into one result: RMSE (8 fraction bits), PSNR in dB (8 fraction bits)
// and a status code (0 ok, 1 zero error, 2 zero range). The back is a
// shared sequential datapath: bit-serial division, square root (skipped
// when the mean saturates), then three log2 evaluations, each a normalize
// loop followed by squaring steps, all skipped on zero range or zero error;
// a set runs from queue to result register this way, plus any wait for pop.
// Input stalls only when a last pair finds both queue entries taken.
module error_stats_rmse_psnr (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ers_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output ers_pkg::rsp_type rsp_data
);
   import ers_pkg::*;

   snap_type      snap_wr, snap_rd;
   queue_ctl_type qctl;
   logic          snap_push, snap_pop, q_full, q_empty;

   assign qctl.push = snap_push;
   assign qctl.pop  = snap_pop;

   ers_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .snap_push (snap_push),
      .snap_data (snap_wr),
      .snap_full (q_full)
   );

   ers_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (qctl),
      .wr_data (snap_wr),
      .rd_data (snap_rd),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   ers_back u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_data  (snap_rd),
      .snap_empty (q_empty),
      .snap_pop   (snap_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/core/ers_checker.sv
`include "assert_macros.svh"

module ers_checker (
   input logic             clock,
   input logic             reset,
   input logic             empty,
   input logic             pop,
   input ers_pkg::rsp_type rsp_data
);
   import ers_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_data))
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty)
   `ASSERT_IMPLIES(a_total_nonzero, clock, reset, !empty, rsp_data.sample_total != '0)
   `ASSERT_IMPLIES(a_zero_range, clock, reset,
      !empty && rsp_data.status == STATUS_ZERO_RANGE,
      rsp_data.psnr_db == '0 && rsp_data.original_min == rsp_data.original_max)
   `ASSERT_IMPLIES(a_zero_error, clock, reset,
      !empty && rsp_data.status == STATUS_ZERO_ERROR,
      rsp_data.rmse == '0 && rsp_data.max_abs_error == '0)

endmodule

bind error_stats_rmse_psnr ers_checker u_ers_checker (.*);
